@@ rtl/core/servo_clamp_force_controller_assert.svh @@
// ----------------------------------------------------------------------------
// servo clamp force controller assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef SERVO_CLAMP_FORCE_CONTROLLER_ASSERT_SVH
`define SERVO_CLAMP_FORCE_CONTROLLER_ASSERT_SVH

// same-cycle implication, off while reset is high
`define SCFC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scfc check failed");

// next-cycle implication, off while reset is high
`define SCFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scfc check failed");

`endif

@@ rtl/core/scfc_pkg.sv @@
// ----------------------------------------------------------------------------
// scfc_pkg
// shared types, widths and codes of the servo clamp force controller
// ----------------------------------------------------------------------------
package scfc_pkg;

   // field widths
   localparam int SAMPLE_BITS = 16;
   localparam int PULSE_W     = 12;
   localparam int GAIN_W      = 6;
   localparam int GUARD_W     = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = (SAMPLE_BITS > PULSE_W) ? SAMPLE_BITS : PULSE_W;
   localparam int REQ_TDATA_W = ((5 + 2 * SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_TDATA_W = 24;

   // reset values of the control registers
   localparam logic [SAMPLE_BITS-1:0] FORCE_THR_RST   = SAMPLE_BITS'(300);
   localparam logic [SAMPLE_BITS-1:0] CURRENT_THR_RST = SAMPLE_BITS'(300);
   localparam logic [SAMPLE_BITS-1:0] RELEASE_THR_RST = SAMPLE_BITS'(50);
   localparam logic [PULSE_W-1:0]     PULSE_OPEN_RST  = PULSE_W'(2000);
   localparam logic [PULSE_W-1:0]     PULSE_CLOSE_RST = PULSE_W'(1000);
   localparam logic [PULSE_W-1:0]     PULSE_STOP_RST  = PULSE_W'(1520);
   localparam logic [GAIN_W-1:0]      BAND_GAIN_RST   = GAIN_W'(13);
   localparam logic [GUARD_W-1:0]     GUARD_TICKS_RST = GUARD_W'(50);

   // command codes, code 3 behaves as float
   localparam logic [1:0] CMD_FLOAT = 2'd0;
   localparam logic [1:0] CMD_CLOSE = 2'd1;
   localparam logic [1:0] CMD_OPEN  = 2'd2;

   // status message codes
   localparam logic [1:0] MSG_FLOATING = 2'd0;
   localparam logic [1:0] MSG_CLAMPED  = 2'd1;
   localparam logic [1:0] MSG_RELEASED = 2'd2;

   // operating mode
   typedef enum logic [1:0] {
      MODE_FLOAT = 2'd0,
      MODE_CLOSE = 2'd1,
      MODE_OPEN  = 2'd2
   } mode_type;

   // control register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_FORCE_THR   = 3'd0,
      REG_CURRENT_THR = 3'd1,
      REG_RELEASE_THR = 3'd2,
      REG_PULSE_OPEN  = 3'd3,
      REG_PULSE_CLOSE = 3'd4,
      REG_PULSE_STOP  = 3'd5,
      REG_BAND_GAIN   = 3'd6,
      REG_GUARD_TICKS = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] force_threshold;
      logic [SAMPLE_BITS-1:0] current_threshold;
      logic [SAMPLE_BITS-1:0] release_threshold;
      logic [PULSE_W-1:0]     pulse_open;
      logic [PULSE_W-1:0]     pulse_close;
      logic [PULSE_W-1:0]     pulse_stop;
      logic [GAIN_W-1:0]      band_gain_tenths;
      logic [GUARD_W-1:0]     guard_ticks;
   } cfg_type;

   typedef struct packed {
      logic                   command_valid;
      logic [1:0]             command;
      logic [SAMPLE_BITS-1:0] force_sample;
      logic [SAMPLE_BITS-1:0] current_sample;
      logic                   switch_a;
      logic                   switch_b;
   } item_type;

   typedef struct packed {
      logic [PULSE_W-1:0] servo_pulse;
      logic               message_valid;
      logic [1:0]         message;
      logic               red_led;
      logic               green_led;
   } result_type;

endpackage

@@ rtl/core/scfc_csr.sv @@
// ----------------------------------------------------------------------------
// scfc_csr
// control register file, write only, one register per write
// ----------------------------------------------------------------------------
module scfc_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [scfc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [scfc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output scfc_pkg::cfg_type                 cfg
);
   import scfc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // decode the write onto the addressed register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            REG_FORCE_THR:   cfg_in.force_threshold   = csr_wdata[SAMPLE_BITS-1:0];
            REG_CURRENT_THR: cfg_in.current_threshold = csr_wdata[SAMPLE_BITS-1:0];
            REG_RELEASE_THR: cfg_in.release_threshold = csr_wdata[SAMPLE_BITS-1:0];
            REG_PULSE_OPEN:  cfg_in.pulse_open        = csr_wdata[PULSE_W-1:0];
            REG_PULSE_CLOSE: cfg_in.pulse_close       = csr_wdata[PULSE_W-1:0];
            REG_PULSE_STOP:  cfg_in.pulse_stop        = csr_wdata[PULSE_W-1:0];
            REG_BAND_GAIN:   cfg_in.band_gain_tenths  = csr_wdata[GAIN_W-1:0];
            REG_GUARD_TICKS: cfg_in.guard_ticks       = csr_wdata[GUARD_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   // register storage with power-on defaults
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.force_threshold   <= FORCE_THR_RST;
         cfg_ff.current_threshold <= CURRENT_THR_RST;
         cfg_ff.release_threshold <= RELEASE_THR_RST;
         cfg_ff.pulse_open        <= PULSE_OPEN_RST;
         cfg_ff.pulse_close       <= PULSE_CLOSE_RST;
         cfg_ff.pulse_stop        <= PULSE_STOP_RST;
         cfg_ff.band_gain_tenths  <= BAND_GAIN_RST;
         cfg_ff.guard_ticks       <= GUARD_TICKS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/core/scfc_step.sv @@
// ----------------------------------------------------------------------------
// scfc_step
// per-tick mode update: command decode, limit guard, closing, holding loop,
// opening and floating, with the controller state registers
// ----------------------------------------------------------------------------
module scfc_step (
   input  logic                 clock,
   input  logic                 reset,
   input  scfc_pkg::cfg_type    cfg,
   input  logic                 advance,
   input  scfc_pkg::item_type   item,
   output scfc_pkg::result_type result
);
   import scfc_pkg::*;

   localparam int PROD_W = SAMPLE_BITS + GAIN_W;
   localparam int SP_W   = PULSE_W + 2;

   // controller state
   mode_type               mode_ff, mode_in;
   logic                   holding_ff, holding_in;
   logic [SAMPLE_BITS-1:0] captured_ff, captured_in;
   logic [PULSE_W-1:0]     servo_ff, servo_in;
   logic [GUARD_W-1:0]     guard_count_ff, guard_count_in;
   logic                   guard_opens_ff, guard_opens_in;
   logic                   green_ff, green_in;

   // intermediate values
   logic [1:0]              cmd;
   logic                    sa_pressed;
   logic                    sb_pressed;
   logic [PROD_W-1:0]       force_x10;
   logic [PROD_W-1:0]       band_upper;
   logic signed [SP_W-1:0]  pulse_adj;
   logic signed [SP_W-1:0]  pulse_sat;
   logic [GUARD_W-1:0]      guard_len;

   assign cmd        = (item.command == 2'd3) ? CMD_FLOAT : item.command;
   assign sa_pressed = ~item.switch_a;
   assign sb_pressed = ~item.switch_b;
   assign force_x10  = PROD_W'(item.force_sample) * PROD_W'(10);
   assign band_upper = PROD_W'(captured_ff) * PROD_W'(cfg.band_gain_tenths);
   assign guard_len  = (cfg.guard_ticks == '0) ? GUARD_W'(1) : cfg.guard_ticks;

   // bang-bang step of the holding loop, then saturation to [close, open]
   always_comb begin
      pulse_adj = signed'({2'b00, servo_ff});
      if (force_x10 >= band_upper) begin
         pulse_adj = pulse_adj + SP_W'(1);
      end else if (item.force_sample <= captured_ff) begin
         pulse_adj = pulse_adj - SP_W'(1);
      end
      if (pulse_adj < signed'({2'b00, cfg.pulse_close})) begin
         pulse_sat = signed'({2'b00, cfg.pulse_close});
      end else if (pulse_adj > signed'({2'b00, cfg.pulse_open})) begin
         pulse_sat = signed'({2'b00, cfg.pulse_open});
      end else begin
         pulse_sat = pulse_adj;
      end
   end

   // command, then the tick's action in the resulting mode
   always_comb begin
      mode_in        = mode_ff;
      holding_in     = holding_ff;
      captured_in    = captured_ff;
      servo_in       = servo_ff;
      guard_count_in = guard_count_ff;
      guard_opens_in = guard_opens_ff;
      green_in       = green_ff;
      result         = '0;

      // command decode
      if (item.command_valid) begin
         case (mode_ff)
            MODE_CLOSE: begin
               if (cmd == CMD_OPEN) begin
                  if (holding_ff) green_in = 1'b0;
                  mode_in    = MODE_OPEN;
                  holding_in = 1'b0;
               end
            end
            MODE_OPEN: begin
               if (cmd != CMD_OPEN) begin
                  green_in   = 1'b0;
                  mode_in    = mode_type'(cmd);
                  holding_in = 1'b0;
               end
            end
            default: begin
               if (cmd != CMD_FLOAT) begin
                  mode_in    = mode_type'(cmd);
                  holding_in = 1'b0;
               end
            end
         endcase
      end

      // action
      if (guard_count_ff != '0) begin
         guard_count_in     = guard_count_ff - GUARD_W'(1);
         result.servo_pulse = guard_opens_ff ? cfg.pulse_open : cfg.pulse_close;
         result.red_led     = 1'b1;
      end else if (mode_in != MODE_OPEN && (sa_pressed || sb_pressed)) begin
         guard_opens_in     = sa_pressed;
         guard_count_in     = guard_len - GUARD_W'(1);
         result.servo_pulse = sa_pressed ? cfg.pulse_open : cfg.pulse_close;
         result.red_led     = 1'b1;
      end else begin
         case (mode_in)
            MODE_OPEN: begin
               if (sb_pressed) begin
                  green_in           = 1'b0;
                  result.servo_pulse = cfg.pulse_stop;
               end else begin
                  green_in             = 1'b1;
                  result.servo_pulse   = cfg.pulse_open;
                  result.message_valid = 1'b1;
                  result.message       = (item.force_sample < cfg.release_threshold) ?
                                         MSG_RELEASED : MSG_FLOATING;
               end
            end
            MODE_CLOSE: begin
               result.message_valid = 1'b1;
               if (holding_in) begin
                  servo_in           = pulse_sat[PULSE_W-1:0];
                  result.servo_pulse = pulse_sat[PULSE_W-1:0];
                  result.message     = MSG_CLAMPED;
               end else if (item.force_sample >= cfg.force_threshold &&
                            item.current_sample >= cfg.current_threshold) begin
                  green_in           = 1'b1;
                  captured_in        = item.force_sample;
                  servo_in           = cfg.pulse_stop;
                  holding_in         = 1'b1;
                  result.servo_pulse = cfg.pulse_stop;
                  result.message     = MSG_CLAMPED;
               end else begin
                  result.servo_pulse = cfg.pulse_close;
                  result.message     = MSG_FLOATING;
               end
            end
            default: begin
               result.servo_pulse   = cfg.pulse_stop;
               result.message_valid = 1'b1;
               result.message       = MSG_FLOATING;
            end
         endcase
      end

      result.green_led = green_in;
   end

   // state registers, updated once per processed tick
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_FLOAT;
         holding_ff     <= 1'b0;
         captured_ff    <= '0;
         servo_ff       <= PULSE_STOP_RST;
         guard_count_ff <= '0;
         guard_opens_ff <= 1'b0;
         green_ff       <= 1'b0;
      end else if (advance) begin
         mode_ff        <= mode_in;
         holding_ff     <= holding_in;
         captured_ff    <= captured_in;
         servo_ff       <= servo_in;
         guard_count_ff <= guard_count_in;
         guard_opens_ff <= guard_opens_in;
         green_ff       <= green_in;
      end
   end

endmodule

@@ rtl/core/servo_clamp_force_controller.sv @@
// ----------------------------------------------------------------------------
// servo_clamp_force_controller
// servo clamp force controller, one sample tick in, one result out
// ----------------------------------------------------------------------------
// usage:
//   req_* carries one sample tick per transfer (command, force and current
//   samples, active-low limit switches); rsp_* returns one result per tick
//   (servo pulse, status message, led states) in the same order.
//   csr_* writes the control registers; write only while no tick is in flight.
// flow and throughput:
//   a tick accepted at one edge lands in the input register, is evaluated by
//   the mode logic and captured in the result register when that register is
//   free, then rsp_tvalid rises. one tick per cycle sustained while rsp_tready
//   is high, set by the single pass through the mode logic per cycle.
// reset:
//   synchronous, active high; empties both registers, restores the control
//   register defaults and returns the controller to floating with the stop
//   pulse and both leds off.
// stall:
//   while rsp_tready is low the result holds; one more tick may wait in the
//   input register, after which req_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module servo_clamp_force_controller (
   input  logic                                clock,
   input  logic                                reset,
   // sample tick channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // command_valid, command, force_sample, current_sample, switch_a,
   // switch_b, zero fill
   input  logic [scfc_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // servo_pulse, message_valid, message, red_led, green_led, zero fill
   output logic [scfc_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // control register write port
   input  logic                                csr_we,
   input  logic [scfc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [scfc_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import scfc_pkg::*;

   localparam int REQ_USED_W = 5 + 2 * SAMPLE_BITS;
   localparam int RSP_USED_W = PULSE_W + 5;

   cfg_type    cfg;
   item_type   item_ff;
   item_type   item_unpacked;
   result_type result;
   logic       in_valid_ff;
   logic       out_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_in;
   logic       advance;

   // unpack the request payload, lowest field first
   assign item_unpacked.command_valid  = req_tdata[0];
   assign item_unpacked.command        = req_tdata[2:1];
   assign item_unpacked.force_sample   = req_tdata[3 +: SAMPLE_BITS];
   assign item_unpacked.current_sample = req_tdata[3 + SAMPLE_BITS +: SAMPLE_BITS];
   assign item_unpacked.switch_a       = req_tdata[3 + 2 * SAMPLE_BITS];
   assign item_unpacked.switch_b       = req_tdata[4 + 2 * SAMPLE_BITS];

   // handshake: the input stage moves on when the result register is empty or its result is taken
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // control registers
   scfc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // mode logic and controller state
   scfc_step u_step (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .advance (advance),
      .item    (item_ff),
      .result  (result)
   );

   // pack the result, lowest field first
   assign rsp_data_in = {{(RSP_TDATA_W - RSP_USED_W){1'b0}},
                         result.green_led, result.red_led, result.message,
                         result.message_valid, result.servo_pulse};

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= item_unpacked;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // upper request bits are zero fill
   logic unused_req_fill;
   assign unused_req_fill = ^req_tdata[REQ_TDATA_W-1:REQ_USED_W];

endmodule

@@ rtl/core/scfc_checker.sv @@
// ----------------------------------------------------------------------------
// scfc_checker
// port-level checks of the servo clamp force controller, bound to the top
// ----------------------------------------------------------------------------
`include "servo_clamp_force_controller_assert.svh"

module scfc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [scfc_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import scfc_pkg::*;

   // a stalled result holds its payload
   `SCFC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                     rsp_tvalid && $stable(rsp_tdata))

   // no message code without a message
   `SCFC_ASSERT_NOW(a_msg_zero, clock, reset, rsp_tvalid && !rsp_tdata[PULSE_W],
                    rsp_tdata[PULSE_W+2:PULSE_W+1] == MSG_FLOATING)

   // a guard tick never sends a message
   `SCFC_ASSERT_NOW(a_guard_silent, clock, reset, rsp_tvalid && rsp_tdata[PULSE_W+3],
                    !rsp_tdata[PULSE_W])

   // an empty result side always leaves room for a new tick
   `SCFC_ASSERT_NOW(a_room, clock, reset, !rsp_tvalid && req_tvalid, req_tready)

endmodule

bind servo_clamp_force_controller scfc_checker u_scfc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
